// ===== design/pasp_pkg.sv =====
// pasp_pkg: constants, types and the per-beat header decision for the
// pes audio packet stripper. no dependencies.
package pasp_pkg;

  localparam int WIN_LEN = 6;
  localparam int FILL_W  = 3;
  localparam int SKIP_W  = 17;

  localparam logic [7:0] SC_ZERO       = 8'h00;
  localparam logic [7:0] SC_ONE        = 8'h01;
  localparam logic [7:0] ID_AUDIO_A    = 8'hC0;
  localparam logic [7:0] ID_AUDIO_B    = 8'hC1;
  localparam logic [7:0] ID_VIDEO_LO   = 8'hE0;
  localparam logic [7:0] ID_VIDEO_HI   = 8'hEF;
  localparam logic [7:0] KEEP_ID_RESET = ID_AUDIO_A;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

  typedef logic [7:0] win_t [WIN_LEN];

  typedef struct packed {
    logic [7:0]        data;
    logic              found;
    logic [SKIP_W-1:0] skip;
    logic              zeroing;
    logic              seen;
  } head_res_t;

  // decide what the oldest window byte becomes and how the skip state moves
  function automatic head_res_t head_decide(
    input win_t              win,
    input logic              may_match,
    input logic [SKIP_W-1:0] skip,
    input logic              zeroing,
    input logic              seen,
    input logic [7:0]        keep_id
  );
    head_res_t r;
    logic [7:0] id;
    logic       is_start;
    logic [SKIP_W-1:0] pkt_rem;
    r.data    = win[0];
    r.found   = 1'b0;
    r.skip    = skip;
    r.zeroing = zeroing;
    r.seen    = seen;
    id        = win[3];
    is_start  = (win[0] == SC_ZERO) && (win[1] == SC_ZERO) && (win[2] == SC_ONE);
    // six header bytes plus length, minus the byte going out now
    pkt_rem   = {1'b0, win[4], win[5]} + SKIP_W'(WIN_LEN - 1);
    if (skip != '0) begin
      if (zeroing) begin
        r.data = 8'h00;
      end
      r.skip = skip - SKIP_W'(1);
      if (r.skip == '0) begin
        r.zeroing = 1'b0;
      end
    end else if (may_match && is_start) begin
      if ((id == ID_AUDIO_A) || (id == ID_AUDIO_B)) begin
        if ((id == ID_AUDIO_B) && !seen) begin
          r.seen  = 1'b1;
          r.found = 1'b1;
        end
        r.zeroing = (keep_id != id);
        r.skip    = pkt_rem;
        if (r.zeroing) begin
          r.data = 8'h00;
        end
      end else if (id inside {[ID_VIDEO_LO:ID_VIDEO_HI]}) begin
        r.zeroing = 1'b0;
        r.skip    = pkt_rem;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/pes_audio_packet_stripper.sv =====
// pes_audio_packet_stripper: six-byte lookahead window, packet skip counter
// and one output register. depends on pasp_pkg.
//
// a byte leaves when it is oldest in a full window and a beat is accepted, or
// on the frame-end flush. throughput: one beat per cycle while scanning and
// the output is free; a frame-end beat holds the input while the window drains
// through the single output register. rst (synchronous) empties the window,
// clears skip, audio-seen flag and output valid, sets keep_stream_id to 0xc0.
module pes_audio_packet_stripper
  import pasp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       keep_stream_id_wr_en,
  input  logic [7:0] keep_stream_id_wr_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // frame_end
  input  logic       s_axis_tuser,   // [0] track_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // out_last
  output logic       m_axis_tuser    // [0] second_audio_found
);

  logic [7:0]        keep_id;
  win_t              win;
  win_t              win_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [SKIP_W-1:0] skip;
  logic [SKIP_W-1:0] skip_next;
  logic              zeroing;
  logic              zeroing_next;
  logic              seen;
  logic              seen_next;
  logic              flushing;
  logic              flushing_next;
  logic              out_valid_next;
  logic              out_load;
  logic              out_last_next;

  logic              out_free;
  logic              accept;
  logic              flush_step;
  logic              emit_now;
  logic              seen_eff;
  head_res_t         head;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !flushing && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign flush_step    = flushing && out_free;
  assign emit_now      = accept && (fill == FILL_FULL);

  // track start clears the flag before this beat is tested
  assign seen_eff = (accept && s_axis_tuser) ? 1'b0 : seen;

  assign head = head_decide(win, !flushing, skip, zeroing, seen_eff, keep_id);

  always_comb begin
    win_next       = win;
    fill_next      = fill;
    skip_next      = skip;
    zeroing_next   = zeroing;
    seen_next      = seen_eff;
    flushing_next  = flushing;
    out_load       = 1'b0;
    out_last_next  = 1'b0;
    out_valid_next = m_axis_tvalid && !m_axis_tready;

    if (emit_now || flush_step) begin
      out_load     = 1'b1;
      skip_next    = head.skip;
      zeroing_next = head.zeroing;
      seen_next    = head.seen;
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_next[i] = win[i+1];
      end
      win_next[WIN_LEN-1] = 8'h00;
    end

    if (accept) begin
      if (emit_now) begin
        win_next[WIN_LEN-1] = s_axis_tdata;
      end else begin
        win_next[fill] = s_axis_tdata;
        fill_next      = fill + FILL_W'(1);
      end
      if (s_axis_tlast) begin
        flushing_next = 1'b1;
      end
    end

    if (flush_step) begin
      fill_next = fill - FILL_W'(1);
      if (fill == FILL_ONE) begin
        // window drained: frame ends here, any open skip is dropped
        out_last_next = 1'b1;
        flushing_next = 1'b0;
        skip_next     = '0;
        zeroing_next  = 1'b0;
      end
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_id       <= KEEP_ID_RESET;
      fill          <= '0;
      skip          <= '0;
      zeroing       <= 1'b0;
      seen          <= 1'b0;
      flushing      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (keep_stream_id_wr_en) begin
        keep_id <= keep_stream_id_wr_data;
      end
      fill          <= fill_next;
      skip          <= skip_next;
      zeroing       <= zeroing_next;
      seen          <= seen_next;
      flushing      <= flushing_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (out_load) begin
      m_axis_tdata <= head.data;
      m_axis_tlast <= out_last_next;
      m_axis_tuser <= head.found;
    end
  end

endmodule
